### hdl/c3mf_pkg.sv
`default_nettype none

package c3mf_pkg;

    localparam int DEF_MAX_WIDTH      = 2048;
    localparam int DEF_COEF_FRAC_BITS = 12;

    localparam int MAX_HEIGHT = 2048;
    localparam int DIM_W      = 12;
    localparam int ROW_CNT_W  = 11;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 48;
    localparam int COEF_BITS  = 16;
    localparam int CFG_IDX_W  = 3;

    localparam int PROD_W = 24;
    localparam int ROW_W  = 26;
    localparam int ACC_W  = 28;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [COEF_W-1:0] COEF_RESET = 48'h01C7_01C7_01C7;
    localparam logic [DIM_W-1:0]  DIM_RESET  = 12'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_TOP = 3'd0,
        REG_COEF_MID = 3'd1,
        REG_COEF_BOT = 3'd2,
        REG_WIDTH    = 3'd3,
        REG_HEIGHT   = 3'd4
    } c3mf_reg_t;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } c3mf_action_t;

    typedef struct packed {
        logic is_flush;
        logic sel_older;
        logic emit;
        logic border;
        logic eof;
    } c3mf_ctl_t;

    typedef struct packed {
        logic accept;
        logic draining;
    } c3mf_front_sts_t;

endpackage

`default_nettype wire

### hdl/conv3x3_mask_filter_core.sv
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_stall  action, pixel
// out      source     out_valid / out_stall out_pixel, end_of_frame
// cfg      sink       cfg_wr_en            cfg_index, cfg_data
//
// One item per clock sustained while no result is stalled; an item
// leaving the four-entry command queue passes in turn through the line
// store read, window, multiply, row-sum and round back pipeline stages.
// Reset clears counters, queue and pipeline valids; line stores and window
// hold no reset value.
// A stalled result freezes the back pipeline; the queue keeps taking
// transfers until full, then in_stall rises.

module conv3x3_mask_filter_core import c3mf_pkg::*; #(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 action,
    input  wire logic [PIX_W-1:0]     pixel,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [PIX_W-1:0]          out_pixel,
    output logic                      end_of_frame,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COEF_W-1:0]    cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int QW = $bits(c3mf_ctl_t) + AW + PIX_W;

    logic [COEF_W-1:0] coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;

    c3mf_ctl_t         front_ctl, head_ctl;
    logic [AW-1:0]     front_addr, head_addr;
    logic [PIX_W-1:0]  front_pixel, head_pixel;
    c3mf_front_sts_t   front_sts;
    logic              q_push, q_pop, q_full, q_valid;
    logic [QW-1:0]     q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg <= COEF_RESET;
            coef_mid_reg <= COEF_RESET;
            coef_bot_reg <= COEF_RESET;
            width_reg    <= DIM_RESET;
            height_reg   <= DIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_COEF_TOP: coef_top_reg <= cfg_data;
                REG_COEF_MID: coef_mid_reg <= cfg_data;
                REG_COEF_BOT: coef_bot_reg <= cfg_data;
                REG_WIDTH:    width_reg    <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:   height_reg   <= cfg_data[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    c3mf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .pixel        (pixel),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_full       (q_full),
        .push         (q_push),
        .cmd_ctl      (front_ctl),
        .cmd_addr     (front_addr),
        .cmd_pixel    (front_pixel),
        .sts          (front_sts)
    );

    assign q_wdata = {front_ctl, front_addr, front_pixel};
    assign {head_ctl, head_addr, head_pixel} = q_rdata;

    c3mf_queue #(
        .DATA_W (QW)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata),
        .full   (q_full)
    );

    c3mf_back #(
        .MAX_WIDTH      (MAX_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (q_valid),
        .head_ctl        (head_ctl),
        .head_addr       (head_addr),
        .head_pixel      (head_pixel),
        .pop             (q_pop),
        .coef_top_row    (coef_top_reg),
        .coef_mid_row    (coef_mid_reg),
        .coef_bottom_row (coef_bot_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_pixel       (out_pixel),
        .end_of_frame    (end_of_frame)
    );

`ifndef NO_ASSERTIONS
    a_queue_on_work: assert property (@(posedge clk) disable iff (!rst_n)
        (front_sts.accept && (action == ACT_PIXEL || front_sts.draining)) |-> q_push)
        else $error("accepted pixel or drain transfer not queued");

    a_frozen_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !q_pop)
        else $error("queue popped while result stalled");

    a_single_eof: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_frame && !out_stall) |=> !(out_valid && end_of_frame))
        else $error("back-to-back end of frame");
`endif

endmodule

`default_nettype wire

### hdl/c3mf_front.sv
`default_nettype none

module c3mf_front import c3mf_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         action,
    input  wire logic [PIX_W-1:0]             pixel,
    input  wire logic [DIM_W-1:0]             image_width,
    input  wire logic [DIM_W-1:0]             image_height,
    input  wire logic                         q_full,
    output logic                              push,
    output c3mf_ctl_t                         cmd_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]      cmd_addr,
    output logic [PIX_W-1:0]                  cmd_pixel,
    output c3mf_front_sts_t                   sts
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int FW = $clog2(MAX_WIDTH + 2);
    localparam int EW = ((WW > DIM_W) ? WW : DIM_W) + 2;

    logic [AW-1:0]        col_reg, col_next;
    logic [ROW_CNT_W-1:0] row_reg, row_next;
    logic [FW-1:0]        flush_reg, flush_next;

    logic [EW-1:0] w_ext, h_ext, w_eff, h_eff;
    logic [EW-1:0] x_e, y_e, r_e, c_e, k_e;
    logic [FW-1:0] k;
    logic          accept, draining, last_col, last_row, interior;

    always_comb
    begin
        w_ext = EW'(image_width);
        h_ext = EW'(image_height);
        if (w_ext < EW'(3))
        begin
            w_eff = EW'(3);
        end
        else if (w_ext > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
        if (h_ext < EW'(3))
        begin
            h_eff = EW'(3);
        end
        else if (h_ext > EW'(MAX_HEIGHT))
        begin
            h_eff = EW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = h_ext;
        end
    end

    assign in_stall     = q_full;
    assign accept       = in_valid && !q_full;
    assign draining     = (flush_reg != '0);
    assign sts.accept   = accept;
    assign sts.draining = draining;

    always_comb
    begin
        k        = flush_reg - FW'(1);
        k_e      = EW'(k);
        x_e      = EW'(col_reg);
        y_e      = EW'(row_reg);
        last_col = (x_e + EW'(1)) >= w_eff;
        last_row = (y_e + EW'(1)) >= h_eff;
        if (col_reg != '0)
        begin
            r_e = y_e - EW'(1);
            c_e = x_e - EW'(1);
        end
        else
        begin
            r_e = y_e - EW'(2);
            c_e = w_eff - EW'(1);
        end
        interior = (r_e >= EW'(1)) && ((r_e + EW'(2)) <= h_eff)
                && (c_e >= EW'(1)) && ((c_e + EW'(2)) <= w_eff);

        col_next   = col_reg;
        row_next   = row_reg;
        flush_next = flush_reg;
        push       = 1'b0;
        cmd_ctl    = '0;
        cmd_addr   = col_reg;
        cmd_pixel  = pixel;

        priority if (accept && draining)
        begin
            push              = 1'b1;
            cmd_ctl.is_flush  = 1'b1;
            cmd_ctl.emit      = 1'b1;
            cmd_ctl.border    = 1'b1;
            cmd_ctl.sel_older = (k == '0);
            cmd_ctl.eof       = (k_e >= w_eff);
            cmd_addr          = (k == '0) ? AW'(w_eff - EW'(1)) : AW'(k - FW'(1));
            flush_next        = cmd_ctl.eof ? '0 : flush_reg + FW'(1);
        end
        else if (accept && (action == ACT_PIXEL))
        begin
            push           = 1'b1;
            cmd_ctl.emit   = (y_e >= EW'(2)) || ((y_e == EW'(1)) && (x_e >= EW'(1)));
            cmd_ctl.border = !interior;
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next   = '0;
                    flush_next = FW'(1);
                end
                else
                begin
                    row_next = ROW_CNT_W'(y_e + EW'(1));
                end
            end
            else
            begin
                col_next = AW'(x_e + EW'(1));
            end
        end
        else
        begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            flush_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            flush_reg <= flush_next;
        end
    end

endmodule

`default_nettype wire

### hdl/c3mf_queue.sv
`default_nettype none

module c3mf_queue import c3mf_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              pop,
    output logic                   rvalid,
    output logic [DATA_W-1:0]      rdata,
    output logic                   full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign rvalid  = (cnt_reg != '0);
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && rvalid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

### hdl/c3mf_back.sv
`default_nettype none

module c3mf_back import c3mf_pkg::*; #(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         head_valid,
    input  wire c3mf_ctl_t                    head_ctl,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] head_addr,
    input  wire logic [PIX_W-1:0]             head_pixel,
    output logic                              pop,
    input  wire logic [COEF_W-1:0]            coef_top_row,
    input  wire logic [COEF_W-1:0]            coef_mid_row,
    input  wire logic [COEF_W-1:0]            coef_bottom_row,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [PIX_W-1:0]                  out_pixel,
    output logic                              end_of_frame
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg, wr_data;
    logic               advance, wr_en;

    logic               p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic               out_valid_reg;
    c3mf_ctl_t          p1_ctl_reg, p2_ctl_reg, p3_ctl_reg, p4_ctl_reg;
    logic [AW-1:0]      p1_addr_reg;
    logic [PIX_W-1:0]   p1_pixel_reg, p2_fval_reg, p3_pass_reg, p4_pass_reg;
    logic [PIX_W-1:0]   out_pixel_reg, filt;
    logic               out_eof_reg;

    logic [PIX_W-1:0]          win_reg  [3][3];
    logic [COEF_W-1:0]         coef_rows [3];
    logic signed [PROD_W-1:0]  prod_reg [3][3];
    logic signed [ROW_W-1:0]   row_sum_reg [3];
    logic signed [ACC_W-1:0]   acc;

    assign coef_rows[0] = coef_top_row;
    assign coef_rows[1] = coef_mid_row;
    assign coef_rows[2] = coef_bottom_row;

    assign advance = !(out_valid_reg && out_stall);
    assign pop     = advance && head_valid;
    assign wr_en   = advance && p1_valid_reg && !p1_ctl_reg.is_flush;
    assign wr_data = {rd_data_reg[PIX_W-1:0], p1_pixel_reg};

    // line store entry: older row in the high byte, newer row in the low byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[p1_addr_reg] <= wr_data;
        end
        if (pop)
        begin
            if (wr_en && (p1_addr_reg == head_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= line_mem[head_addr];
            end
        end
    end

    always_comb
    begin
        acc = ACC_W'(row_sum_reg[0]) + ACC_W'(row_sum_reg[1])
            + ACC_W'(row_sum_reg[2]) + ROUND_HALF;
        if (acc[ACC_W-1])
        begin
            filt = '0;
        end
        else if (|acc[ACC_W-2:COEF_FRAC_BITS+PIX_W])
        begin
            filt = '1;
        end
        else
        begin
            filt = acc[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg  <= head_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            out_valid_reg <= p4_valid_reg && p4_ctl_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_ctl_reg   <= head_ctl;
            p1_addr_reg  <= head_addr;
            p1_pixel_reg <= head_pixel;

            // shift window on pixel transfers only
            if (p1_valid_reg && !p1_ctl_reg.is_flush)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= rd_data_reg[2*PIX_W-1:PIX_W];
                win_reg[1][2] <= rd_data_reg[PIX_W-1:0];
                win_reg[2][2] <= p1_pixel_reg;
            end
            p2_ctl_reg  <= p1_ctl_reg;
            p2_fval_reg <= p1_ctl_reg.sel_older ? rd_data_reg[2*PIX_W-1:PIX_W]
                                                : rd_data_reg[PIX_W-1:0];

            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= PROD_W'($signed(coef_rows[r][c*COEF_BITS +: COEF_BITS])
                                      * $signed({1'b0, win_reg[r][c]}));
                end
            end
            p3_ctl_reg  <= p2_ctl_reg;
            p3_pass_reg <= p2_ctl_reg.is_flush ? p2_fval_reg : win_reg[1][1];

            for (int r = 0; r < 3; r++)
            begin
                row_sum_reg[r] <= ROW_W'(prod_reg[r][0]) + ROW_W'(prod_reg[r][1])
                                + ROW_W'(prod_reg[r][2]);
            end
            p4_ctl_reg  <= p3_ctl_reg;
            p4_pass_reg <= p3_pass_reg;

            out_pixel_reg <= p4_ctl_reg.border ? p4_pass_reg : filt;
            out_eof_reg   <= p4_ctl_reg.eof;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_pixel    = out_pixel_reg;
    assign end_of_frame = out_eof_reg;

endmodule

`default_nettype wire
